FILE: rtl/tsi_pkg.sv
// Package for the turtle symbol interpreter: widths, codes, reset values,
// the quarter-wave sine table in Q1.14 and the angle helpers.
// Used by turtle_symbol_interpreter_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsi_pkg;

    // Parameter defaults
    localparam int STACK_DEPTH_DEF     = 64;
    localparam int COORD_FRAC_BITS_DEF = 4;

    // Field widths
    localparam int COORD_W    = 20;
    localparam int HEAD_W     = 9;
    localparam int SYM_W      = 8;
    localparam int TURN_W     = 9;
    localparam int STEP_W     = 10;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Sine magnitudes are Q1.14, up to 16384 inclusive
    localparam int TRIG_W    = 15;
    localparam int TRIG_FRAC = 14;

    // Result kinds
    typedef logic [KIND_W-1:0] t_result_kind;
    localparam t_result_kind RK_SEGMENT   = 2'd0;
    localparam t_result_kind RK_OVERFLOW  = 2'd1;
    localparam t_result_kind RK_UNDERFLOW = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FORWARD_SYM = 3'd0;
    localparam t_cfg_idx CFG_LEFT_SYM    = 3'd1;
    localparam t_cfg_idx CFG_RIGHT_SYM   = 3'd2;
    localparam t_cfg_idx CFG_TURN_STEP   = 3'd3;
    localparam t_cfg_idx CFG_STEP_LENGTH = 3'd4;

    // Input item kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    // Fixed branch symbols
    localparam logic [SYM_W-1:0] SYM_PUSH = 8'd91;
    localparam logic [SYM_W-1:0] SYM_POP  = 8'd93;

    // Reset values
    localparam logic [SYM_W-1:0]  FORWARD_SYM_RST = 8'd70;
    localparam logic [SYM_W-1:0]  LEFT_SYM_RST    = 8'd43;
    localparam logic [SYM_W-1:0]  RIGHT_SYM_RST   = 8'd45;
    localparam logic [TURN_W-1:0] TURN_STEP_RST   = 9'd90;
    localparam logic [STEP_W-1:0] STEP_LENGTH_RST = 10'd10;
    localparam logic [HEAD_W-1:0] HEADING_RST     = 9'd10;

    // Angles in whole degrees
    localparam logic [HEAD_W-1:0] DEG_QUARTER = 9'd90;
    localparam logic [HEAD_W-1:0] DEG_HALF    = 9'd180;
    localparam logic [HEAD_W-1:0] DEG_3QUART  = 9'd270;
    localparam logic [HEAD_W-1:0] DEG_FULL    = 9'd360;

    // Decoded actions of one item
    typedef struct packed {
        logic start;
        logic fwd;
        logic left;
        logic right;
        logic push;
        logic pop;
    } t_dec;

    // Reduce a sum below twice a full turn into 0..359.
    function automatic logic [HEAD_W-1:0] deg_wrap(input logic [HEAD_W:0] s);
        logic [HEAD_W:0] r;
        begin
            r = (s >= {1'b0, DEG_FULL}) ? s - {1'b0, DEG_FULL} : s;
            return r[HEAD_W-1:0];
        end
    endfunction

    // Heading plus a quarter turn, for the cosine lookup.
    function automatic logic [HEAD_W-1:0] deg_add90(input logic [HEAD_W-1:0] h);
        begin
            return deg_wrap({1'b0, h} + {1'b0, DEG_QUARTER});
        end
    endfunction

    // Sign of the sine of a heading in 0..359.
    function automatic logic sin_neg(input logic [HEAD_W-1:0] h);
        begin
            return (h > DEG_HALF);
        end
    endfunction

    // Magnitude of the sine of a heading in 0..359, Q1.14.
    function automatic logic [TRIG_W-1:0] sin_mag(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] f;
        logic [TRIG_W-1:0] v;
        begin
            if (h <= DEG_QUARTER) begin
                f = h;
            end else if (h <= DEG_HALF) begin
                f = DEG_HALF - h;
            end else if (h <= DEG_3QUART) begin
                f = h - DEG_HALF;
            end else begin
                f = DEG_FULL - h;
            end
            case (f[6:0])
                7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
                7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
                7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
                7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
                7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
                7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
                7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
                7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
                7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
                7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
                7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
                7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
                7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
                7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
                7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
                7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
                7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
                7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
                7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
                7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
                7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
                7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
                7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
                7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
                7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
                7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
                7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
                7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
                7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
                7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
                7'd90: v = 15'd16384;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/turtle_symbol_interpreter_top.sv
// Turtle interpreter for an L-system symbol stream: pen and heading
// registers, branch stack in tsi_ram. Depends on tsi_pkg and tsi_ram.
//
// An item passes the first and second stage; its result is then registered.
// A new item is accepted only once the previous one commits: the stack memory
// read and the trig multiply of one item finish before the next reads the pen state.
// Reset: synchronous, active low; registers go to their defaults, pen to
// zero, heading to 10 degrees, stack empty. The stack memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module turtle_symbol_interpreter_top #(
    parameter int STACK_DEPTH     = tsi_pkg::STACK_DEPTH_DEF,
    parameter int COORD_FRAC_BITS = tsi_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [tsi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tsi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_kind,
    input  wire logic [tsi_pkg::SYM_W-1:0]        i_symbol,
    input  wire logic signed [tsi_pkg::COORD_W-1:0] i_start_x,
    input  wire logic signed [tsi_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [tsi_pkg::HEAD_W-1:0]       i_start_heading,
    // Output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [tsi_pkg::KIND_W-1:0]            o_result_kind,
    output logic signed [tsi_pkg::COORD_W-1:0]    o_from_x,
    output logic signed [tsi_pkg::COORD_W-1:0]    o_from_y,
    output logic signed [tsi_pkg::COORD_W-1:0]    o_to_x,
    output logic signed [tsi_pkg::COORD_W-1:0]    o_to_y
);

    localparam int CW   = tsi_pkg::COORD_W;
    localparam int HW   = tsi_pkg::HEAD_W;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int NW   = $clog2(STACK_DEPTH + 1);
    localparam int FW   = 2 * CW + HW;
    localparam int MW   = tsi_pkg::TRIG_W + tsi_pkg::STEP_W;
    localparam int RW   = MW + COORD_FRAC_BITS + 1;
    localparam int HALF_Q14 = 1 << (tsi_pkg::TRIG_FRAC - 1);

    // Configuration registers
    logic [tsi_pkg::SYM_W-1:0]  r_cfg_fwd;
    logic [tsi_pkg::SYM_W-1:0]  r_cfg_left;
    logic [tsi_pkg::SYM_W-1:0]  r_cfg_right;
    logic [tsi_pkg::TURN_W-1:0] r_cfg_turn;
    logic [tsi_pkg::STEP_W-1:0] r_cfg_step;

    // Turtle state
    logic [CW-1:0] r_pen_x;
    logic [CW-1:0] r_pen_y;
    logic [HW-1:0] r_heading;
    logic [NW-1:0] r_count;

    // First stage: accepted item
    logic                      r_s1_valid;
    logic                      r_s1_kind;
    logic [tsi_pkg::SYM_W-1:0] r_s1_symbol;
    logic [CW-1:0]             r_s1_sx;
    logic [CW-1:0]             r_s1_sy;
    logic [HW-1:0]             r_s1_sh;

    // Second stage: decoded item, trig values, stack read in flight
    logic                        r_s2_valid;
    tsi_pkg::t_dec               r_s2_dec;
    logic [CW-1:0]               r_s2_sx;
    logic [CW-1:0]               r_s2_sy;
    logic [HW-1:0]               r_s2_sh;
    logic [tsi_pkg::TRIG_W-1:0]  r_s2_cos_mag;
    logic                        r_s2_cos_neg;
    logic [tsi_pkg::TRIG_W-1:0]  r_s2_sin_mag;
    logic                        r_s2_sin_neg;

    // Output register
    logic                        r_out_valid;
    tsi_pkg::t_result_kind       r_out_kind;
    logic [CW-1:0]               r_out_fx;
    logic [CW-1:0]               r_out_fy;
    logic [CW-1:0]               r_out_tx;
    logic [CW-1:0]               r_out_ty;

    logic                        w_in_accept;
    logic                        w_s2_fire;
    logic                        w_s2_has_res;
    logic                        w_full;
    logic                        w_empty;
    tsi_pkg::t_dec               w_s1_dec;
    logic [HW-1:0]               w_s1_cos_deg;
    logic [AW-1:0]               w_rd_addr;
    logic [FW-1:0]               w_rd_data;
    logic                        w_wr_en;
    logic [FW-1:0]               w_wr_data;
    logic [MW-1:0]               w_mag_x;
    logic [MW-1:0]               w_mag_y;
    logic [RW-1:0]               w_rnd_x;
    logic [RW-1:0]               w_rnd_y;
    logic [CW-1:0]               w_dx;
    logic [CW-1:0]               w_dy;
    logic [CW-1:0]               w_to_x;
    logic [CW-1:0]               w_to_y;
    logic [HW-1:0]               w_turn_mod;
    logic [HW-1:0]               w_head_l;
    logic [HW-1:0]               w_head_r;
    logic [CW-1:0]               w_pen_fx;
    logic [CW-1:0]               w_pen_fy;
    logic [CW-1:0]               n_pen_x;
    logic [CW-1:0]               n_pen_y;
    logic [HW-1:0]               n_heading;
    logic [NW-1:0]               n_count;

    // Handshake: a new item enters only once the previous one commits
    assign w_full       = (r_count == NW'(STACK_DEPTH));
    assign w_empty      = (r_count == '0);
    assign w_s2_has_res = r_s2_dec.fwd || (r_s2_dec.push && w_full)
                          || (r_s2_dec.pop && w_empty);
    assign w_s2_fire    = r_s2_valid && (!w_s2_has_res || !r_out_valid || !i_out_stall);
    assign o_in_stall   = r_s1_valid || (r_s2_valid && !w_s2_fire);
    assign w_in_accept  = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fwd   <= tsi_pkg::FORWARD_SYM_RST;
            r_cfg_left  <= tsi_pkg::LEFT_SYM_RST;
            r_cfg_right <= tsi_pkg::RIGHT_SYM_RST;
            r_cfg_turn  <= tsi_pkg::TURN_STEP_RST;
            r_cfg_step  <= tsi_pkg::STEP_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsi_pkg::CFG_FORWARD_SYM: r_cfg_fwd   <= i_cfg_data[tsi_pkg::SYM_W-1:0];
                tsi_pkg::CFG_LEFT_SYM:    r_cfg_left  <= i_cfg_data[tsi_pkg::SYM_W-1:0];
                tsi_pkg::CFG_RIGHT_SYM:   r_cfg_right <= i_cfg_data[tsi_pkg::SYM_W-1:0];
                tsi_pkg::CFG_TURN_STEP:   r_cfg_turn  <= i_cfg_data[tsi_pkg::TURN_W-1:0];
                tsi_pkg::CFG_STEP_LENGTH: r_cfg_step  <= i_cfg_data[tsi_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // First stage: decode the symbol and look up sine and cosine
    always_comb begin
        w_s1_dec.start = (r_s1_kind == tsi_pkg::KIND_START);
        w_s1_dec.fwd   = !w_s1_dec.start && (r_s1_symbol == r_cfg_fwd);
        w_s1_dec.left  = !w_s1_dec.start && (r_s1_symbol == r_cfg_left);
        w_s1_dec.right = !w_s1_dec.start && (r_s1_symbol == r_cfg_right);
        w_s1_dec.push  = !w_s1_dec.start && (r_s1_symbol == tsi_pkg::SYM_PUSH);
        w_s1_dec.pop   = !w_s1_dec.start && (r_s1_symbol == tsi_pkg::SYM_POP);
    end

    assign w_s1_cos_deg = tsi_pkg::deg_add90(r_heading);

    // The pop address is read here; the state has already taken the previous item
    assign w_rd_addr = AW'(r_count - NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_accept;
            if (r_s1_valid) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_fire) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_kind   <= i_kind;
            r_s1_symbol <= i_symbol;
            r_s1_sx     <= i_start_x;
            r_s1_sy     <= i_start_y;
            r_s1_sh     <= i_start_heading;
        end
        if (r_s1_valid) begin
            r_s2_dec     <= w_s1_dec;
            r_s2_sx      <= r_s1_sx;
            r_s2_sy      <= r_s1_sy;
            r_s2_sh      <= r_s1_sh;
            r_s2_cos_mag <= tsi_pkg::sin_mag(w_s1_cos_deg);
            r_s2_cos_neg <= tsi_pkg::sin_neg(w_s1_cos_deg);
            r_s2_sin_mag <= tsi_pkg::sin_mag(r_heading);
            r_s2_sin_neg <= tsi_pkg::sin_neg(r_heading);
        end
    end

    // Branch stack memory: x, y and heading of each pushed frame
    tsi_ram #(
        .WIDTH (FW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wr_data),
        .i_re    (r_s1_valid),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Second stage: forward move, rounded half away from zero
    assign w_mag_x = MW'(r_s2_cos_mag) * MW'(r_cfg_step);
    assign w_mag_y = MW'(r_s2_sin_mag) * MW'(r_cfg_step);
    assign w_rnd_x = (RW'(w_mag_x) << COORD_FRAC_BITS) + RW'(HALF_Q14);
    assign w_rnd_y = (RW'(w_mag_y) << COORD_FRAC_BITS) + RW'(HALF_Q14);

    always_comb begin
        w_dx = CW'(w_rnd_x[RW-1:tsi_pkg::TRIG_FRAC]);
        w_dy = CW'(w_rnd_y[RW-1:tsi_pkg::TRIG_FRAC]);
        if (r_s2_cos_neg) begin
            w_dx = CW'(0) - w_dx;
        end
        if (r_s2_sin_neg) begin
            w_dy = CW'(0) - w_dy;
        end
    end

    assign w_to_x = r_pen_x + w_dx;
    assign w_to_y = r_pen_y + w_dy;

    // Turns, applied after the move and before any push
    assign w_turn_mod = (r_cfg_turn >= tsi_pkg::DEG_FULL) ? r_cfg_turn - tsi_pkg::DEG_FULL
                                                          : r_cfg_turn;
    assign w_head_l = r_s2_dec.left
                      ? tsi_pkg::deg_wrap({1'b0, r_heading} + {1'b0, w_turn_mod})
                      : r_heading;
    assign w_head_r = r_s2_dec.right
                      ? tsi_pkg::deg_wrap({1'b0, w_head_l} + {1'b0, tsi_pkg::DEG_FULL}
                                          - {1'b0, w_turn_mod})
                      : w_head_l;

    assign w_pen_fx  = r_s2_dec.fwd ? w_to_x : r_pen_x;
    assign w_pen_fy  = r_s2_dec.fwd ? w_to_y : r_pen_y;
    assign w_wr_en   = w_s2_fire && r_s2_dec.push && !w_full;
    assign w_wr_data = {w_pen_fx, w_pen_fy, w_head_r};

    // Next turtle state
    always_comb begin
        n_pen_x   = w_pen_fx;
        n_pen_y   = w_pen_fy;
        n_heading = w_head_r;
        n_count   = r_count;
        if (r_s2_dec.start) begin
            n_pen_x = r_s2_sx;
            n_pen_y = r_s2_sy;
            if (r_s2_sh != '0) begin
                n_heading = tsi_pkg::deg_wrap({1'b0, r_s2_sh});
            end else begin
                n_heading = r_heading;
            end
        end else begin
            if (r_s2_dec.push && !w_full) begin
                n_count = r_count + NW'(1);
            end
            if (r_s2_dec.pop && !w_empty) begin
                n_count   = r_count - NW'(1);
                n_pen_x   = w_rd_data[FW-1 -: CW];
                n_pen_y   = w_rd_data[HW +: CW];
                n_heading = w_rd_data[HW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_heading <= tsi_pkg::HEADING_RST;
            r_count   <= '0;
        end else if (w_s2_fire) begin
            r_pen_x   <= n_pen_x;
            r_pen_y   <= n_pen_y;
            r_heading <= n_heading;
            r_count   <= n_count;
        end
    end

    // Output register: a segment wins over a stack flag from the same symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_fire && w_s2_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && w_s2_has_res) begin
            if (r_s2_dec.fwd) begin
                r_out_kind <= tsi_pkg::RK_SEGMENT;
                r_out_fx   <= r_pen_x;
                r_out_fy   <= r_pen_y;
                r_out_tx   <= w_to_x;
                r_out_ty   <= w_to_y;
            end else begin
                r_out_kind <= r_s2_dec.push ? tsi_pkg::RK_OVERFLOW : tsi_pkg::RK_UNDERFLOW;
                r_out_fx   <= '0;
                r_out_fy   <= '0;
                r_out_tx   <= '0;
                r_out_ty   <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_from_x      = r_out_fx;
    assign o_from_y      = r_out_fy;
    assign o_to_x        = r_out_tx;
    assign o_to_y        = r_out_ty;

    // Checks on the pipeline and the turtle state
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading < tsi_pkg::DEG_FULL)
        else $error("heading out of range");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && r_s2_valid))
        else $error("two items in flight");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_s1_valid && !r_s2_valid))
        else $error("accepted item did not enter first stage");

    a_push_pop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> !(r_s2_dec.push && r_s2_dec.pop))
        else $error("push and pop decoded together");

endmodule

`default_nettype wire

FILE: rtl/tsi_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the branch stack of the turtle interpreter; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module tsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
